// ----- sv/rtli_pkg.sv -----
// shared types and constants of the radial table interpolator
package rtli_pkg;

  localparam int unsigned MAX_STATIONS_DEF  = 64;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam int unsigned RADIUS_W = 32;
  localparam int unsigned VALUE_W  = 32;

  typedef enum logic [1:0] {
    FUNC_BEGIN  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_RESV   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOTABLE = 2'd1,
    STAT_ORDER   = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  // one stored station as it sits in the table memory
  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic [VALUE_W-1:0]  axial;
    logic [VALUE_W-1:0]  swirl;
  } station_t;

  localparam int unsigned STATION_W = $bits(station_t);

endpackage

// ----- sv/rtli_if.sv -----
// request and response channel interfaces
interface rtli_req_if import rtli_pkg::*; ();
  logic                       valid;
  logic                       ready;
  func_e                      func;
  logic        [RADIUS_W-1:0] radius;
  logic signed [VALUE_W-1:0]  axial_value;
  logic signed [VALUE_W-1:0]  swirl_value;
  logic                       last_station;

  modport source (output valid, func, radius, axial_value, swirl_value, last_station,
                  input ready);
  modport sink   (input valid, func, radius, axial_value, swirl_value, last_station,
                  output ready);
endinterface

interface rtli_rsp_if import rtli_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] axial_result;
  logic signed [VALUE_W-1:0] swirl_result;
  status_e                   status;

  modport source (output valid, axial_result, swirl_result, status, input ready);
  modport sink   (input valid, axial_result, swirl_result, status, output ready);
endinterface

// ----- sv/rtli_ram.sv -----
// generic simple dual-port ram with registered read
module rtli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/rtli_div.sv -----
// restoring divider for the interpolation fraction, one quotient bit per cycle
module rtli_div import rtli_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [RADIUS_W-1:0]      num_i,
  input  logic [RADIUS_W-1:0]      den_i,
  output logic                     done_o,
  output logic [FRACTION_BITS:0]   quo_o
);

  localparam int unsigned QW = FRACTION_BITS + 1;
  localparam int unsigned CNTW = $clog2(QW + 1);

  logic [RADIUS_W:0]   rem_q, rem_d;
  logic [RADIUS_W-1:0] den_q;
  logic [QW-1:0]       quo_q, quo_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                fits;
  logic [RADIUS_W:0]   rem_sub;

  // numerator is num << FRACTION_BITS; the first step takes the integer bit
  always_comb begin
    fits    = (rem_q >= {1'b0, den_q});
    rem_sub = fits ? (rem_q - {1'b0, den_q}) : rem_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quo_d  = '0;
      cnt_d  = CNTW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = {rem_sub[RADIUS_W-1:0], 1'b0};
      quo_d = {quo_q[QW-2:0], fits};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- sv/radial_table_linear_interpolator_top.sv -----
// radial station table with clamped piecewise-linear interpolation, top level
//
//   channel  | dir | payload                                              | taken when
//   req_i    | in  | func, radius, axial_value, swirl_value, last_station | valid && ready
//   rsp_o    | out | axial_result, swirl_result, status                   | valid && ready
//
// a load writes the station to the table memory at accept;
// a query scans the stored stations one per cycle through the memory read port,
// then, between two stations, runs the divider, one multiply and one add;
// the divider yields a quotient of FRACTION_BITS+1 bits
// reset clears the station count and the table flags, the memory is not cleared
// a new item is taken while a finished result still waits in the output register
module radial_table_linear_interpolator_top import rtli_pkg::*; #(
  parameter int unsigned MAX_STATIONS  = MAX_STATIONS_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtli_req_if.sink    req_i,
  rtli_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(MAX_STATIONS);
  localparam int unsigned CW = $clog2(MAX_STATIONS + 1);
  localparam int unsigned QW = FRACTION_BITS + 1;
  localparam int unsigned PW = QW + VALUE_W + 2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]       count_q, count_d;
  logic                table_valid_q, table_valid_d;
  logic                load_intact_q, load_intact_d;
  logic [RADIUS_W-1:0] last_rad_q, last_rad_d;

  logic [AW-1:0]       idx_q, idx_d;
  logic [RADIUS_W-1:0] qr_q, qr_d;
  station_t            prev_q, prev_d;
  logic [VALUE_W-1:0]  lo_ax_q, lo_ax_d, lo_sw_q, lo_sw_d;
  logic signed [VALUE_W:0] diff_ax_q, diff_ax_d, diff_sw_q, diff_sw_d;
  logic signed [PW-1:0]    prod_ax_q, prod_ax_d, prod_sw_q, prod_sw_d;

  logic [VALUE_W-1:0]  res_ax_q, res_ax_d, res_sw_q, res_sw_d;
  status_e             res_st_q, res_st_d;

  logic                out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]  out_ax_q, out_ax_d, out_sw_q, out_sw_d;
  status_e             out_st_q, out_st_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  station_t            ram_wdata, cur;

  logic                div_start, div_done;
  logic [RADIUS_W-1:0] div_num, div_den;
  logic [QW-1:0]       div_quo;

  logic                accept;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  rtli_ram #(
    .WIDTH (STATION_W),
    .DEPTH (MAX_STATIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (cur)
  );

  rtli_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    table_valid_d = table_valid_q;
    load_intact_d = load_intact_q;
    last_rad_d    = last_rad_q;
    idx_d         = idx_q;
    qr_d          = qr_q;
    prev_d        = prev_q;
    lo_ax_d       = lo_ax_q;
    lo_sw_d       = lo_sw_q;
    diff_ax_d     = diff_ax_q;
    diff_sw_d     = diff_sw_q;
    prod_ax_d     = prod_ax_q;
    prod_sw_d     = prod_sw_q;
    res_ax_d      = res_ax_q;
    res_sw_d      = res_sw_q;
    res_st_d      = res_st_q;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '{radius: req_i.radius, axial: req_i.axial_value,
                      swirl: req_i.swirl_value};
    ram_raddr     = '0;
    div_start     = 1'b0;
    div_num       = qr_q - prev_q.radius;
    div_den       = cur.radius - prev_q.radius;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_ax_d = '0;
          res_sw_d = '0;
          res_st_d = STAT_OK;
          state_d  = ST_RESP;
          unique case (req_i.func)
            FUNC_BEGIN: begin
              ram_we        = 1'b1;
              ram_waddr     = '0;
              count_d       = CW'(1);
              last_rad_d    = req_i.radius;
              table_valid_d = req_i.last_station;
              load_intact_d = !req_i.last_station;
            end
            FUNC_APPEND: begin
              priority if (!load_intact_q || count_q == '0) begin
                res_st_d = STAT_NOTABLE;
              end else if (count_q == CW'(MAX_STATIONS)) begin
                count_d       = '0;
                table_valid_d = 1'b0;
                load_intact_d = 1'b0;
                res_st_d      = STAT_FULL;
              end else if (req_i.radius <= last_rad_q) begin
                count_d       = '0;
                table_valid_d = 1'b0;
                load_intact_d = 1'b0;
                res_st_d      = STAT_ORDER;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count_q[AW-1:0];
                count_d    = count_q + CW'(1);
                last_rad_d = req_i.radius;
                if (req_i.last_station) begin
                  table_valid_d = 1'b1;
                  load_intact_d = 1'b0;
                end
              end
            end
            FUNC_QUERY: begin
              if (!table_valid_q) begin
                res_st_d = STAT_NOTABLE;
              end else begin
                qr_d      = req_i.radius;
                idx_d     = '0;
                ram_raddr = '0;
                state_d   = ST_SCAN;
              end
            end
            FUNC_RESV: begin
              res_st_d = STAT_OK;
            end
            default: begin
              res_st_d = STAT_OK;
            end
          endcase
        end
      end

      // one station per cycle: the next read goes out while this one is checked
      ST_SCAN: begin
        if (qr_q <= cur.radius) begin
          if (idx_q == '0) begin
            res_ax_d = cur.axial;
            res_sw_d = cur.swirl;
            state_d  = ST_RESP;
          end else begin
            lo_ax_d   = prev_q.axial;
            lo_sw_d   = prev_q.swirl;
            diff_ax_d = $signed({cur.axial[VALUE_W-1], cur.axial})
                      - $signed({prev_q.axial[VALUE_W-1], prev_q.axial});
            diff_sw_d = $signed({cur.swirl[VALUE_W-1], cur.swirl})
                      - $signed({prev_q.swirl[VALUE_W-1], prev_q.swirl});
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end else if (CW'(idx_q) == count_q - CW'(1)) begin
          // beyond the last station: clamp
          res_ax_d = cur.axial;
          res_sw_d = cur.swirl;
          state_d  = ST_RESP;
        end else begin
          prev_d    = cur;
          idx_d     = idx_q + AW'(1);
          ram_raddr = idx_q + AW'(1);
        end
      end

      ST_DIV: begin
        if (div_done) begin
          prod_ax_d = $signed({1'b0, div_quo}) * diff_ax_q;
          prod_sw_d = $signed({1'b0, div_quo}) * diff_sw_q;
          state_d   = ST_ADD;
        end
      end

      // arithmetic shift floors the scaled step toward minus infinity
      ST_ADD: begin
        res_ax_d = lo_ax_q + prod_ax_q[FRACTION_BITS +: VALUE_W];
        res_sw_d = lo_sw_q + prod_sw_q[FRACTION_BITS +: VALUE_W];
        state_d  = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_ax_d    = out_ax_q;
    out_sw_d    = out_sw_q;
    out_st_d    = out_st_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_RESP && (!out_valid_q || rsp_o.ready)) begin
      out_valid_d = 1'b1;
      out_ax_d    = res_ax_q;
      out_sw_d    = res_sw_q;
      out_st_d    = res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      table_valid_q <= 1'b0;
      load_intact_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      table_valid_q <= table_valid_d;
      load_intact_q <= load_intact_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_rad_q <= last_rad_d;
    idx_q      <= idx_d;
    qr_q       <= qr_d;
    prev_q     <= prev_d;
    lo_ax_q    <= lo_ax_d;
    lo_sw_q    <= lo_sw_d;
    diff_ax_q  <= diff_ax_d;
    diff_sw_q  <= diff_sw_d;
    prod_ax_q  <= prod_ax_d;
    prod_sw_q  <= prod_sw_d;
    res_ax_q   <= res_ax_d;
    res_sw_q   <= res_sw_d;
    res_st_q   <= res_st_d;
    out_ax_q   <= out_ax_d;
    out_sw_q   <= out_sw_d;
    out_st_q   <= out_st_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.axial_result = out_ax_q;
  assign rsp_o.swirl_result = out_sw_q;
  assign rsp_o.status       = out_st_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_STATIONS))
    else $error("station count beyond table depth");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(table_valid_q && load_intact_q))
    else $error("table valid while a load is still open");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  a_rsp_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == ST_RESP))
    else $error("response raised without a finished item");
`endif

endmodule

// ----- test/radial_table_linear_interpolator_top_test.sv -----
// testbench of the radial table interpolator: directed and random loads and queries
`timescale 1ns / 100ps

module radial_table_linear_interpolator_top_test import rtli_pkg::*;;

  localparam int unsigned MAX_ST    = MAX_STATIONS_DEF;
  localparam int unsigned FRAC_BITS = FRACTION_BITS_DEF;
  localparam int          LIMIT     = 1_000_000;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [VALUE_W-1:0] axial;
    logic signed [VALUE_W-1:0] swirl;
    status_e                   status;
  } result_t;

  logic clk_i;
  logic rst_ni;

  rtli_req_if req_if ();
  rtli_rsp_if rsp_if ();

  radial_table_linear_interpolator_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // predicted table contents
  logic [RADIUS_W-1:0]       pred_radius [MAX_ST];
  logic signed [VALUE_W-1:0] pred_axial  [MAX_ST];
  logic signed [VALUE_W-1:0] pred_swirl  [MAX_ST];
  int                        pred_count = 0;
  bit                        pred_valid = 1'b0;
  bit                        pred_open  = 1'b0;

  result_t             expected_q [$];
  logic [RADIUS_W-1:0] load_r [$];   // radii of the latest load, for picking queries
  int                  err_cnt    = 0;
  int                  cycle_cnt  = 0;
  int                  sent_cnt   = 0;
  int                  stall_left = 0;
  bit                  idle_en    = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             expected_q.size());
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [VALUE_W-1:0] blend(input logic signed [VALUE_W-1:0] lo,
                                                      input logic signed [VALUE_W-1:0] hi,
                                                      input longint unsigned frac);
    longint p;
    longint sum;
    p   = longint'(frac) * (longint'(hi) - longint'(lo));
    // arithmetic shift floors toward minus infinity
    sum = longint'(lo) + (p >>> FRAC_BITS);
    return sum[VALUE_W-1:0];
  endfunction

  function automatic result_t predict_item(input func_e f, input logic [RADIUS_W-1:0] r,
                                           input logic signed [VALUE_W-1:0] ax,
                                           input logic signed [VALUE_W-1:0] sw,
                                           input logic last_st);
    result_t res;
    int idx;
    longint unsigned num;
    longint unsigned den;
    longint unsigned frac;
    res.axial  = '0;
    res.swirl  = '0;
    res.status = STAT_OK;
    case (f)
      FUNC_BEGIN: begin
        pred_radius[0] = r;
        pred_axial[0]  = ax;
        pred_swirl[0]  = sw;
        pred_count     = 1;
        pred_valid     = last_st;
        pred_open      = !last_st;
      end
      FUNC_APPEND: begin
        if (!pred_open || pred_count == 0) begin
          res.status = STAT_NOTABLE;
        end else if (pred_count >= MAX_ST) begin
          pred_count = 0;
          pred_valid = 1'b0;
          pred_open  = 1'b0;
          res.status = STAT_FULL;
        end else if (r <= pred_radius[pred_count-1]) begin
          pred_count = 0;
          pred_valid = 1'b0;
          pred_open  = 1'b0;
          res.status = STAT_ORDER;
        end else begin
          pred_radius[pred_count] = r;
          pred_axial[pred_count]  = ax;
          pred_swirl[pred_count]  = sw;
          pred_count++;
          if (last_st) begin
            pred_valid = 1'b1;
            pred_open  = 1'b0;
          end
        end
      end
      FUNC_QUERY: begin
        if (!pred_valid) begin
          res.status = STAT_NOTABLE;
        end else if (r <= pred_radius[0]) begin
          res.axial = pred_axial[0];
          res.swirl = pred_swirl[0];
        end else if (r >= pred_radius[pred_count-1]) begin
          res.axial = pred_axial[pred_count-1];
          res.swirl = pred_swirl[pred_count-1];
        end else begin
          idx = 1;
          while (r > pred_radius[idx]) idx++;
          num  = longint'(r - pred_radius[idx-1]);
          den  = longint'(pred_radius[idx] - pred_radius[idx-1]);
          frac = (num << FRAC_BITS) / den;
          res.axial = blend(pred_axial[idx-1], pred_axial[idx], frac);
          res.swirl = blend(pred_swirl[idx-1], pred_swirl[idx], frac);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  // predicts each accepted item, then checks each accepted result
  always @(posedge clk_i) begin : check_p
    result_t want;
    if (rst_ni && req_if.valid && req_if.ready)
      expected_q.push_back(predict_item(req_if.func, req_if.radius, req_if.axial_value,
                                        req_if.swirl_value, req_if.last_station));
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected, axial", rsp_if.axial_result, 0);
      end else begin
        want = expected_q.pop_front();
        if (rsp_if.axial_result !== want.axial)
          report_mismatch("axial_result", rsp_if.axial_result, want.axial);
        if (rsp_if.swirl_result !== want.swirl)
          report_mismatch("swirl_result", rsp_if.swirl_result, want.swirl);
        if (rsp_if.status !== want.status)
          report_mismatch("status", rsp_if.status, want.status);
      end
    end
  end

  // receiver: random idling, or a counted hold-off when one is requested
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !(idle_en && $urandom_range(0, 99) < 12);
      end
    end
  end

  task automatic send_item(input func_e f, input logic [RADIUS_W-1:0] r,
                           input logic signed [VALUE_W-1:0] ax,
                           input logic signed [VALUE_W-1:0] sw, input logic last_st);
    while (idle_en && $urandom_range(0, 99) < 12) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.func         <= f;
    req_if.radius       <= r;
    req_if.axial_value  <= ax;
    req_if.swirl_value  <= sw;
    req_if.last_station <= last_st;
    do @(posedge clk_i); while (!req_if.ready);
    if (f != FUNC_RESV) sent_cnt++;
  endtask

  task automatic send_query(input logic [RADIUS_W-1:0] r);
    send_item(FUNC_QUERY, r, $urandom, $urandom, $urandom_range(0, 1));
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_table();
    send_query('0);
    send_query('1);
    send_item(FUNC_APPEND, 32'h0005_0000, 32'sd1, 32'sd2, 1'b1);
    send_item(FUNC_RESV, '1, '1, '1, 1'b1);
  endtask

  task automatic test_single_station();
    send_item(FUNC_BEGIN, 32'h0001_8000, VAL_MIN, VAL_MAX, 1'b1);
    send_query('0);
    send_query(32'h0001_8000);
    send_query('1);
    // load is closed once the table is valid
    send_item(FUNC_APPEND, 32'h0002_0000, 32'sd7, 32'sd9, 1'b1);
  endtask

  task automatic test_extreme_values();
    send_item(FUNC_BEGIN, '0, VAL_MAX, VAL_MIN, 1'b0);
    send_item(FUNC_APPEND, 32'h0001_0000, VAL_MIN, VAL_MAX, 1'b0);
    send_item(FUNC_APPEND, '1, '0, -32'sd1, 1'b1);
    send_query('0);
    send_query(32'h0000_8000);
    send_query(32'h0001_0000);
    send_query(32'h0001_0001);
    send_query(32'h7FFF_0000);
    send_query(32'hFFFF_FFFE);
    send_query('1);
  endtask

  task automatic test_bad_order();
    send_item(FUNC_BEGIN, 32'd100, 32'sd1, 32'sd1, 1'b0);
    send_item(FUNC_APPEND, 32'd100, 32'sd2, 32'sd2, 1'b0);
    send_item(FUNC_APPEND, 32'd200, 32'sd3, 32'sd3, 1'b1);
    send_query(32'd150);
    send_item(FUNC_BEGIN, 32'd200, 32'sd4, 32'sd4, 1'b0);
    send_item(FUNC_APPEND, 32'd100, 32'sd5, 32'sd5, 1'b1);
  endtask

  task automatic test_query_during_load();
    send_item(FUNC_BEGIN, 32'd10, -32'sd4096, 32'sd4096, 1'b0);
    send_query(32'd15);
    send_item(FUNC_APPEND, 32'd20, 32'sd4096, -32'sd4096, 1'b1);
    send_query(32'd15);
  endtask

  // builds a strictly rising load, sometimes broken, left open or overflowing
  task automatic load_random_table(input int n_force, input bit overflow_force);
    int n;
    int broken_at;
    bit overflow;
    bit close_load;
    longint unsigned span;
    logic [RADIUS_W-1:0] r;
    logic [RADIUS_W-1:0] prev;
    int pick;
    pick = $urandom_range(0, 99);
    if (n_force > 0)  n = n_force;
    else if (pick < 4)  n = MAX_ST;
    else if (pick < 10) n = $urandom_range(9, MAX_ST - 1);
    else                n = $urandom_range(1, 8);
    prev = ($urandom_range(0, 99) < 20) ? '0 : $urandom_range(0, 32'h8000_0000);
    span = (64'hFFFF_FFFF - prev) / n;
    if ($urandom_range(0, 99) < 20) span = $urandom_range(1, 16);
    broken_at  = (n > 1 && $urandom_range(0, 99) < 8) ? $urandom_range(1, n - 1) : -1;
    overflow   = overflow_force || (n == MAX_ST && $urandom_range(0, 1));
    close_load = overflow_force ? 1'b0 : ($urandom_range(0, 99) < 85);
    load_r.delete();
    for (int k = 0; k < n; k++) begin
      if (k == 0)              r = prev;
      else if (k == broken_at) r = prev - $urandom_range(0, (prev < 1000) ? prev : 1000);
      else                     r = prev + $urandom_range(1, span);
      send_item((k == 0) ? FUNC_BEGIN : FUNC_APPEND, r, rand_value(), rand_value(),
                close_load && (k == n - 1));
      load_r.push_back(r);
      prev = r;
    end
    if (overflow) send_item(FUNC_APPEND, prev + 1, rand_value(), rand_value(), 1'b1);
  endtask

  task automatic run_queries(input int nq);
    int sel;
    int k;
    logic [RADIUS_W-1:0] lo;
    logic [RADIUS_W-1:0] hi;
    for (int q = 0; q < nq; q++) begin
      sel = $urandom_range(0, 99);
      if (load_r.size() < 2 || sel < 10) begin
        send_query((sel & 1) ? $urandom : ((sel & 2) ? '1 : '0));
      end else if (sel < 70) begin
        k  = $urandom_range(0, load_r.size() - 2);
        lo = load_r[k];
        hi = load_r[k+1];
        send_query((hi > lo) ? lo + $urandom_range(0, hi - lo) : lo);
      end else if (sel < 85) begin
        send_query(load_r[$urandom_range(0, load_r.size() - 1)]);
      end else if (sel < 92) begin
        send_query($urandom_range(0, load_r[0]));
      end else begin
        send_query($urandom_range(load_r[load_r.size()-1], 32'hFFFF_FFFF));
      end
    end
  endtask

  task automatic test_full_table();
    load_random_table(MAX_ST, 1'b1);
    run_queries(2);
    load_random_table(MAX_ST, 1'b0);
    run_queries(4);
  endtask

  task automatic test_random_tables(input int n_items);
    int stop_at;
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      load_random_table(0, 1'b0);
      run_queries($urandom_range(2, 8));
      // noise: any function with any content
      if ($urandom_range(0, 99) < 15)
        repeat ($urandom_range(1, 3))
          send_item(func_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                    $urandom_range(0, 1));
    end
  endtask

  task automatic test_backpressure();
    load_random_table(8, 1'b0);
    stall_left = 400;
    run_queries(24);
  endtask

  initial begin
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.func         <= FUNC_BEGIN;
    req_if.radius       <= '0;
    req_if.axial_value  <= '0;
    req_if.swirl_value  <= '0;
    req_if.last_station <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_single_station();
    test_extreme_values();
    test_bad_order();
    test_query_during_load();
    test_full_table();
    test_random_tables(600);
    idle_en = 1'b0;
    test_random_tables(200);
    idle_en = 1'b1;
    test_backpressure();
    test_random_tables(500);

    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
